// ===== src/ihrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihrc_pkg
// types and constants shared by the ipv4 header receive check block
// ----------------------------------------------------------------------------
package ihrc_pkg;

    localparam logic [16:0] MIN_HEADER   = 17'd20;
    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [31:0] BCAST_ADDR   = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX_COUNT    = 16'hFFFF;
    localparam logic [16:0] SAT_FRAME    = 17'h1_0000;

    localparam logic [15:0] IDX_VER_IHL  = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI  = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO  = 16'd3;
    localparam logic [15:0] IDX_PROTO    = 16'd9;
    localparam logic [15:0] IDX_CSUM_HI  = 16'd10;
    localparam logic [15:0] IDX_CSUM_LO  = 16'd11;
    localparam logic [15:0] IDX_SRC_0    = 16'd12;
    localparam logic [15:0] IDX_SRC_3    = 16'd15;
    localparam logic [15:0] IDX_DST_0    = 16'd16;
    localparam logic [15:0] IDX_DST_3    = 16'd19;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [1:0]  PC_ICMP      = 2'd0;
    localparam logic [1:0]  PC_UDP       = 2'd1;
    localparam logic [1:0]  PC_TCP       = 2'd2;
    localparam logic [1:0]  PC_OTHER     = 2'd3;

    typedef enum logic [2:0] {
        V_ACCEPT       = 3'd0,
        V_TOO_SHORT    = 3'd1,
        V_BAD_VERSION  = 3'd2,
        V_BAD_IHL      = 3'd3,
        V_BAD_LENGTH   = 3'd4,
        V_BAD_CHECKSUM = 3'd5,
        V_NOT_LOCAL    = 3'd6
    } t_verdict;

    // header state after the current beat has been folded in
    typedef struct packed {
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  proto_byte;
        logic [15:0] rx_checksum;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] sum;
        logic [16:0] frame_len;
    } t_hdr;

    typedef struct packed {
        t_verdict    verdict;
        logic [1:0]  proto_class;
        logic [7:0]  protocol_number;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
    } t_result;

endpackage

// ===== src/ihrc_accum.sv =====
// ----------------------------------------------------------------------------
// ihrc_accum
// per-frame header capture, byte count and running one's-complement sum
// ----------------------------------------------------------------------------
module ihrc_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output ihrc_pkg::t_hdr o_hdr
);

    logic [15:0] r_byte_count;
    logic [15:0] r_sum;
    logic [7:0]  r_hold;
    logic [7:0]  r_version_ihl;
    logic [15:0] r_total_length;
    logic [7:0]  r_proto_byte;
    logic [15:0] r_rx_checksum;
    logic [31:0] r_src_address;
    logic [31:0] r_dst_address;

    logic [15:0] n_byte_count;
    logic [15:0] n_sum;
    logic [7:0]  n_hold;
    logic [7:0]  n_version_ihl;
    logic [15:0] n_total_length;
    logic [7:0]  n_proto_byte;
    logic [15:0] n_rx_checksum;
    logic [31:0] n_src_address;
    logic [31:0] n_dst_address;

    logic [5:0]  hlen;
    logic [7:0]  word_lo;
    logic [16:0] word_sum;
    logic        in_header;
    logic        csum_byte;

    always_comb begin
        n_version_ihl  = r_version_ihl;
        n_total_length = r_total_length;
        n_proto_byte   = r_proto_byte;
        n_rx_checksum  = r_rx_checksum;
        n_src_address  = r_src_address;
        n_dst_address  = r_dst_address;

        if (r_byte_count == ihrc_pkg::IDX_VER_IHL) begin
            n_version_ihl = i_byte;
        end else if (r_byte_count == ihrc_pkg::IDX_TLEN_HI) begin
            n_total_length = {i_byte, r_total_length[7:0]};
        end else if (r_byte_count == ihrc_pkg::IDX_TLEN_LO) begin
            n_total_length = {r_total_length[15:8], i_byte};
        end else if (r_byte_count == ihrc_pkg::IDX_PROTO) begin
            n_proto_byte = i_byte;
        end else if (r_byte_count == ihrc_pkg::IDX_CSUM_HI) begin
            n_rx_checksum = {i_byte, r_rx_checksum[7:0]};
        end else if (r_byte_count == ihrc_pkg::IDX_CSUM_LO) begin
            n_rx_checksum = {r_rx_checksum[15:8], i_byte};
        end else if (r_byte_count >= ihrc_pkg::IDX_SRC_0 &&
                     r_byte_count <= ihrc_pkg::IDX_SRC_3) begin
            n_src_address = {r_src_address[23:0], i_byte};
        end else if (r_byte_count >= ihrc_pkg::IDX_DST_0 &&
                     r_byte_count <= ihrc_pkg::IDX_DST_3) begin
            n_dst_address = {r_dst_address[23:0], i_byte};
        end

        hlen      = {n_version_ihl[3:0], 2'b00};
        in_header = r_byte_count < {10'd0, hlen};
        csum_byte = (r_byte_count == ihrc_pkg::IDX_CSUM_HI) ||
                    (r_byte_count == ihrc_pkg::IDX_CSUM_LO);
        word_lo   = csum_byte ? 8'd0 : i_byte;
        word_sum  = {1'b0, r_sum} + {1'b0, r_hold, word_lo};

        n_hold = r_hold;
        n_sum  = r_sum;
        if (in_header) begin
            if (!r_byte_count[0]) begin
                n_hold = word_lo;
            end else begin
                // end-around carry
                n_sum = word_sum[15:0] + {15'd0, word_sum[16]};
            end
        end

        n_byte_count = (r_byte_count == ihrc_pkg::MAX_COUNT) ?
                       ihrc_pkg::MAX_COUNT : r_byte_count + 16'd1;

        o_hdr.version_ihl  = n_version_ihl;
        o_hdr.total_length = n_total_length;
        o_hdr.proto_byte   = n_proto_byte;
        o_hdr.rx_checksum  = n_rx_checksum;
        o_hdr.src_address  = n_src_address;
        o_hdr.dst_address  = n_dst_address;
        o_hdr.sum          = n_sum;
        o_hdr.frame_len    = (r_byte_count == ihrc_pkg::MAX_COUNT) ?
                             ihrc_pkg::SAT_FRAME : {1'b0, r_byte_count} + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_byte_count   <= '0;
            r_sum          <= '0;
            r_hold         <= '0;
            r_version_ihl  <= '0;
            r_total_length <= '0;
            r_proto_byte   <= '0;
            r_rx_checksum  <= '0;
            r_src_address  <= '0;
            r_dst_address  <= '0;
        end else if (i_en) begin
            r_byte_count   <= n_byte_count;
            r_sum          <= n_sum;
            r_hold         <= n_hold;
            r_version_ihl  <= n_version_ihl;
            r_total_length <= n_total_length;
            r_proto_byte   <= n_proto_byte;
            r_rx_checksum  <= n_rx_checksum;
            r_src_address  <= n_src_address;
            r_dst_address  <= n_dst_address;
        end
    end

endmodule

// ===== src/ihrc_verdict.sv =====
// ----------------------------------------------------------------------------
// ihrc_verdict
// ordered header checks and result summary for the final beat of a frame
// ----------------------------------------------------------------------------
module ihrc_verdict (
    input  ihrc_pkg::t_hdr    i_hdr,
    input  logic [31:0]       i_local_ip,
    output ihrc_pkg::t_result o_result
);

    logic [5:0]  hlen;
    logic [15:0] computed;
    logic        dst_reject;

    always_comb begin
        hlen       = {i_hdr.version_ihl[3:0], 2'b00};
        computed   = ~i_hdr.sum;
        dst_reject = (i_hdr.dst_address != i_local_ip) &&
                     (i_hdr.dst_address != ihrc_pkg::BCAST_ADDR) &&
                     (i_local_ip != 32'd0);

        o_result.payload_bytes = 16'd0;
        if (i_hdr.frame_len < ihrc_pkg::MIN_HEADER) begin
            o_result.verdict = ihrc_pkg::V_TOO_SHORT;
        end else if (i_hdr.version_ihl[7:4] != ihrc_pkg::IP_VERSION) begin
            o_result.verdict = ihrc_pkg::V_BAD_VERSION;
        end else if ({11'd0, hlen} < ihrc_pkg::MIN_HEADER) begin
            o_result.verdict = ihrc_pkg::V_BAD_IHL;
        end else if (({1'b0, i_hdr.total_length} > i_hdr.frame_len) ||
                     ({10'd0, hlen} > i_hdr.total_length)) begin
            o_result.verdict = ihrc_pkg::V_BAD_LENGTH;
        end else if (computed != i_hdr.rx_checksum) begin
            o_result.verdict = ihrc_pkg::V_BAD_CHECKSUM;
        end else if (dst_reject) begin
            o_result.verdict = ihrc_pkg::V_NOT_LOCAL;
        end else begin
            o_result.verdict       = ihrc_pkg::V_ACCEPT;
            o_result.payload_bytes = i_hdr.total_length - {10'd0, hlen};
        end

        case (i_hdr.proto_byte)
            ihrc_pkg::PROTO_ICMP: o_result.proto_class = ihrc_pkg::PC_ICMP;
            ihrc_pkg::PROTO_UDP:  o_result.proto_class = ihrc_pkg::PC_UDP;
            ihrc_pkg::PROTO_TCP:  o_result.proto_class = ihrc_pkg::PC_TCP;
            default:              o_result.proto_class = ihrc_pkg::PC_OTHER;
        endcase

        o_result.protocol_number = i_hdr.proto_byte;
        o_result.source_ip       = i_hdr.src_address;
        o_result.destination_ip  = i_hdr.dst_address;
        o_result.header_bytes    = hlen;
    end

endmodule

// ===== src/ipv4_header_receive_check_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_receive_check_core
// byte-wide ipv4 header receive check with a single verdict per frame
// ----------------------------------------------------------------------------
// frame bytes enter on the input channel (valid/ready), one beat per byte,
// starting at the ipv4 header, with i_last_byte on the final beat.
// one result beat leaves on the output channel for each frame, carrying the
// verdict and the captured header summary; other beats give no result.
// the local address is written through the config channel, which is always
// ready; write it only while no frame is in flight.
// throughput is one byte per cycle unless a last byte waits on a pending
// result: each beat is held in an input register, folded into the header
// state by one pass of add/compare logic and, on the last beat, the verdict
// is stored in the result register.
// while a result waits, non-final bytes keep flowing; a further last byte
// waits in the input register until the pending result is taken.
// reset clears the header state, the local address and the valid bits of both registers.
// ----------------------------------------------------------------------------
module ipv4_header_receive_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    output logic [1:0]  o_proto_class,
    output logic [7:0]  o_protocol_number,
    output logic [31:0] o_source_ip,
    output logic [31:0] o_destination_ip,
    output logic [5:0]  o_header_bytes,
    output logic [15:0] o_payload_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_local_ip
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    ihrc_pkg::t_result r_result;
    logic [31:0]       r_local_ip;

    logic              n_out_valid;
    logic              s_fire;
    ihrc_pkg::t_hdr    s_hdr;
    ihrc_pkg::t_result s_result;

    assign s_fire      = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s_fire;
    assign o_cfg_ready = 1'b1;
    assign n_out_valid = (s_fire && r_in_last) || (r_out_valid && !i_out_ready);

    ihrc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_hdr   (s_hdr)
    );

    ihrc_verdict u_verdict (
        .i_hdr      (s_hdr),
        .i_local_ip (r_local_ip),
        .o_result   (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_local_ip  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_local_ip <= i_local_ip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
        if (s_fire && r_in_last) begin
            r_result <= s_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_result.verdict;
    assign o_proto_class     = r_result.proto_class;
    assign o_protocol_number = r_result.protocol_number;
    assign o_source_ip       = r_result.source_ip;
    assign o_destination_ip  = r_result.destination_ip;
    assign o_header_bytes    = r_result.header_bytes;
    assign o_payload_bytes   = r_result.payload_bytes;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(s_fire && r_in_last))
        else $error("pending result overwritten");

    // only accepted frames carry a payload length
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict != 3'(ihrc_pkg::V_ACCEPT)) |-> (o_payload_bytes == 16'd0))
        else $error("payload length on rejected frame");

    // an accepted frame has a full header
    a_accept_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == 3'(ihrc_pkg::V_ACCEPT)) |-> (o_header_bytes >= 6'd20))
        else $error("accepted frame with short header");

    // a result appears only after a final beat has been processed
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_fire && r_in_last))
        else $error("result without final beat");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ipv4 header receive check core
// ----------------------------------------------------------------------------
// frames are built byte by byte and driven through the input channel with
// random gaps. each accepted byte is folded into a header predictor that
// keeps its own copy of the captured fields, the running checksum and the
// local address, and queues the expected verdict on the last byte. result
// beats are compared field by field against that queue. a directed set
// covers every verdict and the field extremes, then random frames run
// under several local address settings, one phase with no gaps and one
// with a long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT  = 2000;
    localparam int CHOKE_CYCLES = 400;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rx_beat;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic [7:0]  i_frame_byte      = 8'h00;
    logic        i_last_byte       = 1'b0;
    logic        i_out_ready       = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [31:0] i_local_ip        = 32'h0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_verdict;
    logic [1:0]  o_proto_class;
    logic [7:0]  o_protocol_number;
    logic [31:0] o_source_ip;
    logic [31:0] o_destination_ip;
    logic [5:0]  o_header_bytes;
    logic [15:0] o_payload_bytes;
    logic        o_cfg_ready;

    t_rx_beat          rx_beats[$];
    ihrc_pkg::t_result verdicts_due[$];
    int          beats_queued   = 0;
    int          beats_accepted = 0;
    int          mismatches     = 0;
    int          stall_cycles   = 0;
    int          choke_left     = 0;
    bit          calm_run       = 1'b0;
    bit          choke_req      = 1'b0;

    // predictor state
    logic [31:0] exp_local_ip  = 32'h0;
    logic [15:0] rx_index      = 16'h0;
    logic [16:0] sum_run       = 17'h0;
    logic [7:0]  sum_hi        = 8'h0;
    logic [7:0]  cap_ver_ihl   = 8'h0;
    logic [15:0] cap_total_len = 16'h0;
    logic [7:0]  cap_proto     = 8'h0;
    logic [15:0] cap_checksum  = 16'h0;
    logic [31:0] cap_src       = 32'h0;
    logic [31:0] cap_dst       = 32'h0;

    ipv4_header_receive_check_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_proto_class     (o_proto_class),
        .o_protocol_number (o_protocol_number),
        .o_source_ip       (o_source_ip),
        .o_destination_ip  (o_destination_ip),
        .o_header_bytes    (o_header_bytes),
        .o_payload_bytes   (o_payload_bytes),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_local_ip        (i_local_ip)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [1:0] proto_class_of(logic [7:0] p);
        if (p == ihrc_pkg::PROTO_ICMP) return ihrc_pkg::PC_ICMP;
        if (p == ihrc_pkg::PROTO_UDP) return ihrc_pkg::PC_UDP;
        if (p == ihrc_pkg::PROTO_TCP) return ihrc_pkg::PC_TCP;
        return ihrc_pkg::PC_OTHER;
    endfunction

    function automatic void absorb_rx_byte(logic [7:0] b, logic last);
        logic [15:0]       idx;
        logic [5:0]        hlen;
        logic [7:0]        v;
        logic [16:0]       flen;
        logic [15:0]       want_sum;
        ihrc_pkg::t_result res;
        idx = rx_index;
        if (idx == ihrc_pkg::IDX_VER_IHL) cap_ver_ihl = b;
        else if (idx == ihrc_pkg::IDX_TLEN_HI) cap_total_len[15:8] = b;
        else if (idx == ihrc_pkg::IDX_TLEN_LO) cap_total_len[7:0] = b;
        else if (idx == ihrc_pkg::IDX_PROTO) cap_proto = b;
        else if (idx == ihrc_pkg::IDX_CSUM_HI) cap_checksum[15:8] = b;
        else if (idx == ihrc_pkg::IDX_CSUM_LO) cap_checksum[7:0] = b;
        else if (idx >= ihrc_pkg::IDX_SRC_0 && idx <= ihrc_pkg::IDX_SRC_3)
            cap_src = {cap_src[23:0], b};
        else if (idx >= ihrc_pkg::IDX_DST_0 && idx <= ihrc_pkg::IDX_DST_3)
            cap_dst = {cap_dst[23:0], b};

        hlen = {cap_ver_ihl[3:0], 2'b00};
        if (idx < {10'h0, hlen}) begin
            // checksum field counts as zero
            v = (idx == ihrc_pkg::IDX_CSUM_HI || idx == ihrc_pkg::IDX_CSUM_LO) ? 8'h00 : b;
            if (!idx[0]) begin
                sum_hi = v;
            end else begin
                sum_run = sum_run + {1'b0, sum_hi, v};
                if (sum_run[16]) sum_run = {1'b0, sum_run[15:0]} + 17'd1;
            end
        end
        if (rx_index != ihrc_pkg::MAX_COUNT) rx_index = rx_index + 16'd1;
        if (!last) return;

        flen = (idx == ihrc_pkg::MAX_COUNT) ? ihrc_pkg::SAT_FRAME : {1'b0, idx} + 17'd1;
        want_sum = ~sum_run[15:0];
        res.payload_bytes = 16'h0;
        if (flen < ihrc_pkg::MIN_HEADER) begin
            res.verdict = ihrc_pkg::V_TOO_SHORT;
        end else if (cap_ver_ihl[7:4] != ihrc_pkg::IP_VERSION) begin
            res.verdict = ihrc_pkg::V_BAD_VERSION;
        end else if ({11'h0, hlen} < ihrc_pkg::MIN_HEADER) begin
            res.verdict = ihrc_pkg::V_BAD_IHL;
        end else if ({1'b0, cap_total_len} > flen || {10'h0, hlen} > cap_total_len) begin
            res.verdict = ihrc_pkg::V_BAD_LENGTH;
        end else if (want_sum != cap_checksum) begin
            res.verdict = ihrc_pkg::V_BAD_CHECKSUM;
        end else if (cap_dst != exp_local_ip && cap_dst != ihrc_pkg::BCAST_ADDR
                     && exp_local_ip != 32'h0) begin
            res.verdict = ihrc_pkg::V_NOT_LOCAL;
        end else begin
            res.verdict = ihrc_pkg::V_ACCEPT;
            res.payload_bytes = cap_total_len - {10'h0, hlen};
        end
        res.proto_class     = proto_class_of(cap_proto);
        res.protocol_number = cap_proto;
        res.source_ip       = cap_src;
        res.destination_ip  = cap_dst;
        res.header_bytes    = hlen;
        verdicts_due.push_back(res);

        rx_index      = 16'h0;
        sum_run       = 17'h0;
        sum_hi        = 8'h0;
        cap_ver_ihl   = 8'h0;
        cap_total_len = 16'h0;
        cap_proto     = 8'h0;
        cap_checksum  = 16'h0;
        cap_src       = 32'h0;
        cap_dst       = 32'h0;
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            flag_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function automatic void check_result();
        ihrc_pkg::t_result want;
        if (verdicts_due.size() == 0) begin
            flag_mismatch("result beat with no verdict pending");
            return;
        end
        want = verdicts_due.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(o_verdict));
        check_field("proto_class", 32'(want.proto_class), 32'(o_proto_class));
        check_field("protocol_number", 32'(want.protocol_number), 32'(o_protocol_number));
        check_field("source_ip", want.source_ip, o_source_ip);
        check_field("destination_ip", want.destination_ip, o_destination_ip);
        check_field("header_bytes", 32'(want.header_bytes), 32'(o_header_bytes));
        check_field("payload_bytes", 32'(want.payload_bytes), 32'(o_payload_bytes));
    endfunction

    function automatic void push_beat(logic [7:0] d, logic last);
        rx_beats.push_back('{data: d, last: last});
        beats_queued++;
    endfunction

    // header with a correct or spoilt checksum, cut or padded to flen bytes
    function automatic void queue_frame(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tlen,
                                        logic [7:0] proto, logic [31:0] src,
                                        logic [31:0] dst, bit bad_sum, int flen);
        logic [7:0]  hdr[$];
        logic [16:0] acc;
        logic [15:0] csum;
        int          hlen;
        int          n;
        hlen = int'(ihl) * 4;
        n = (hlen > 20) ? hlen : 20;
        for (int i = 0; i < n; i++) hdr.push_back(8'($urandom));
        hdr[0]  = {ver, ihl};
        hdr[2]  = tlen[15:8];
        hdr[3]  = tlen[7:0];
        hdr[9]  = proto;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        for (int i = 0; i < 4; i++) begin
            hdr[12 + i] = src[31 - 8 * i -: 8];
            hdr[16 + i] = dst[31 - 8 * i -: 8];
        end
        acc = 17'h0;
        for (int i = 0; i < hlen; i += 2) begin
            acc = acc + {1'b0, hdr[i], hdr[i + 1]};
            if (acc[16]) acc = {1'b0, acc[15:0]} + 17'd1;
        end
        csum = ~acc[15:0];
        if (bad_sum) csum = csum ^ 16'($urandom_range(1, 65535));
        hdr[10] = csum[15:8];
        hdr[11] = csum[7:0];
        for (int i = 0; i < flen; i++)
            push_beat((i < n) ? hdr[i] : 8'($urandom), i == flen - 1);
    endfunction

    function automatic logic [31:0] pick_dst(logic [31:0] site);
        int r;
        r = $urandom_range(99);
        if (r < 45) return site;
        if (r < 60) return ihrc_pkg::BCAST_ADDR;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(4))
            0: return ihrc_pkg::PROTO_ICMP;
            1: return ihrc_pkg::PROTO_TCP;
            2: return ihrc_pkg::PROTO_UDP;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int queue_random_frame(logic [31:0] site);
        logic [3:0] ver;
        logic [3:0] ihl;
        int         hlen;
        int         plen;
        int         tlen;
        int         flen;
        bit         bad;
        int         n;
        ver  = ihrc_pkg::IP_VERSION;
        ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        hlen = int'(ihl) * 4;
        plen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
        tlen = hlen + plen;
        flen = tlen + ($urandom_range(1) ? 0 : $urandom_range(6));
        bad  = ($urandom_range(19) == 0);
        if ($urandom_range(99) >= 70) begin
            case ($urandom_range(6))
                0: flen = $urandom_range(1, tlen - 1);
                1: ver = 4'($urandom_range(1, 15)) ^ ihrc_pkg::IP_VERSION;
                2: ihl = 4'($urandom_range(4));
                3: tlen = flen + $urandom_range(1, 100);
                4: tlen = $urandom_range(hlen - 1);
                5: bad = 1'b1;
                default: begin
                    n = $urandom_range(1, 40);
                    for (int i = 0; i < n; i++) push_beat(8'($urandom), i == n - 1);
                    return n;
                end
            endcase
        end
        queue_frame(ver, ihl, 16'(tlen), pick_proto(), $urandom, pick_dst(site), bad, flen);
        return flen;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (beats_accepted != beats_queued || verdicts_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_local_ip(logic [31:0] value);
        @(posedge i_clk);
        i_local_ip  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // input side driver
    always @(posedge i_clk) begin : feed
        t_rx_beat beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (rx_beats.size() != 0 && (calm_run || $urandom_range(99) >= 10)) begin
                beat = rx_beats.pop_front();
                i_in_valid   <= 1'b1;
                i_frame_byte <= beat.data;
                i_last_byte  <= beat.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (choke_req) begin
            choke_left = CHOKE_CYCLES;
            choke_req  = 1'b0;
        end
        if (choke_left > 0) begin
            choke_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm_run || $urandom_range(99) >= 10;
        end
    end

    // monitor and predictor update
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) exp_local_ip = i_local_ip;
            if (o_out_valid && i_out_ready) check_result();
            if (i_in_valid && o_in_ready) begin
                absorb_rx_byte(i_frame_byte, i_last_byte);
                beats_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] site;
        int          items;
        int          frames;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unconfigured address, every verdict but not-local reachable before addressing
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_ICMP,
                    32'h0, 32'h0, 1'b0, 1);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_ICMP,
                    32'h0, 32'h0, 1'b0, 19);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_ICMP,
                    32'h0, ihrc_pkg::BCAST_ADDR, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd28, ihrc_pkg::PROTO_UDP,
                    $urandom, $urandom, 1'b0, 28);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd40, ihrc_pkg::PROTO_TCP,
                    $urandom, $urandom, 1'b0, 44);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd21, 8'hFF,
                    ihrc_pkg::BCAST_ADDR, 32'h0, 1'b0, 21);
        queue_frame(4'd0, 4'd5, 16'd20, ihrc_pkg::PROTO_UDP, $urandom, $urandom, 1'b0, 20);
        queue_frame(4'd15, 4'd5, 16'd20, ihrc_pkg::PROTO_UDP, $urandom, $urandom, 1'b0, 20);
        queue_frame(4'd6, 4'd5, 16'd20, ihrc_pkg::PROTO_UDP, $urandom, $urandom, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd0, 16'd20, ihrc_pkg::PROTO_TCP,
                    $urandom, $urandom, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd4, 16'd20, ihrc_pkg::PROTO_TCP,
                    $urandom, $urandom, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd15, 16'd60, 8'h00,
                    $urandom, $urandom, 1'b0, 60);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd30, ihrc_pkg::PROTO_ICMP,
                    $urandom, $urandom, 1'b0, 25);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd15, 16'd30, ihrc_pkg::PROTO_ICMP,
                    $urandom, $urandom, 1'b0, 30);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd0, ihrc_pkg::PROTO_ICMP,
                    $urandom, $urandom, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_ICMP,
                    $urandom, $urandom, 1'b1, 20);
        wait_idle();

        site = 32'hC0A8_0107;
        write_local_ip(site);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd24, ihrc_pkg::PROTO_UDP,
                    $urandom, site, 1'b0, 24);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd24, ihrc_pkg::PROTO_UDP,
                    $urandom, ihrc_pkg::BCAST_ADDR, 1'b0, 24);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd24, ihrc_pkg::PROTO_UDP,
                    $urandom, ~site, 1'b0, 24);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd24, ihrc_pkg::PROTO_UDP,
                    $urandom, ~site, 1'b1, 24);
        wait_idle();

        write_local_ip(ihrc_pkg::BCAST_ADDR);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_TCP,
                    32'h0, ihrc_pkg::BCAST_ADDR, 1'b0, 20);
        queue_frame(ihrc_pkg::IP_VERSION, 4'd5, 16'd20, ihrc_pkg::PROTO_TCP,
                    ihrc_pkg::BCAST_ADDR, 32'h0, 1'b0, 20);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: site = 32'h0;
                2: site = ihrc_pkg::BCAST_ADDR;
                default: site = $urandom;
            endcase
            write_local_ip(site);
            calm_run = (ph == 1);
            if (ph == 2) choke_req = 1'b1;
            items  = 0;
            frames = 0;
            while (items < 220 || frames < 5) begin
                items += queue_random_frame(site);
                frames++;
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
